// ===== design/sac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int unsigned ADDR_W        = 32;  // address field width
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 4;   // widest register (offset_bits)
  localparam int unsigned OFF_W         = 4;
  localparam int unsigned IB_W          = 3;
  localparam int unsigned NWAY_W        = 3;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned WAY_OUT_W     = 2;
  localparam int unsigned SET_OUT_W     = 6;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned WAY_IDX_MAX_W = 4;   // enough for 16 ways
  localparam int unsigned IB_CAP        = 12;  // hard cap on set index bits

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_INDEX  = 2'd2,
    CFG_WAYS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT        = 2'd0,
    KIND_COMPULSORY = 2'd1,
    KIND_CONFLICT   = 2'd2
  } miss_kind_e;

  // lookup outcome handed from the way logic to the control
  typedef struct packed {
    logic                     hit;
    miss_kind_e               kind;
    logic [WAY_IDX_MAX_W-1:0] way;
  } lookup_t;

endpackage

`default_nettype wire

// ===== design/sac_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sac_ram
// Simple dual-port set memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter  int unsigned DEPTH = 64,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/sac_way_sel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sac_way_sel
// Tag compare across the ways of one set, victim choice and rank update.
// ----------------------------------------------------------------------------
module sac_way_sel #(
  parameter  int unsigned WAYS   = 4,
  parameter  int unsigned TAG_W  = 32,
  parameter  int unsigned RANK_W = 3,
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  wire logic [WAYS-1:0]             rd_valid_i,
  input  wire logic [WAYS-1:0][TAG_W-1:0]  rd_tag_i,
  input  wire logic [WAYS-1:0][RANK_W-1:0] rd_rank_i,
  input  wire logic [TAG_W-1:0]            tag_i,
  input  wire logic [RANK_W-1:0]           nw_i,
  input  wire logic                        lru_i,
  output sac_pkg::lookup_t                 res_o,
  output logic      [WAYS-1:0]             wr_valid_o,
  output logic      [WAYS-1:0][TAG_W-1:0]  wr_tag_o,
  output logic      [WAYS-1:0][RANK_W-1:0] wr_rank_o
);

  import sac_pkg::*;

  // lowest set bit wins
  function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] v);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) idx = WAY_W'(i);
    end
    return idx;
  endfunction

  logic [WAYS-1:0]   inuse, hit_vec, inv_vec, r1_vec, low_vec;
  logic [WAY_W-1:0]  hit_way, vic_way, sel_way;
  logic [RANK_W-1:0] old_rank;
  logic              hit;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      inuse[w]   = 32'(w) < 32'(nw_i);
      hit_vec[w] = inuse[w] && rd_valid_i[w] && (rd_tag_i[w] == tag_i);
      inv_vec[w] = inuse[w] && !rd_valid_i[w];
      r1_vec[w]  = inuse[w] && (rd_rank_i[w] == RANK_W'(1));
    end
  end

  // first in-use way of lowest rank, as independent pairwise compares
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      low_vec[w] = inuse[w];
      for (int v = 0; v < WAYS; v++) begin
        if (v != w && inuse[v]) begin
          if (v < w) low_vec[w] = low_vec[w] && (rd_rank_i[v] >  rd_rank_i[w]);
          else       low_vec[w] = low_vec[w] && (rd_rank_i[v] >= rd_rank_i[w]);
        end
      end
    end
  end

  always_comb begin
    hit      = |hit_vec;
    hit_way  = first_one(hit_vec);
    if (|inv_vec)     vic_way = first_one(inv_vec);
    else if (|r1_vec) vic_way = first_one(r1_vec);
    else              vic_way = first_one(low_vec);
    sel_way  = hit ? hit_way : vic_way;
    old_rank = rd_rank_i[hit_way];

    res_o.hit  = hit;
    res_o.way  = WAY_IDX_MAX_W'(sel_way);
    if (hit)           res_o.kind = KIND_HIT;
    else if (|inv_vec) res_o.kind = KIND_COMPULSORY;
    else               res_o.kind = KIND_CONFLICT;
  end

  // new row contents; ways outside the in-use range pass through
  always_comb begin
    wr_valid_o = rd_valid_i;
    wr_tag_o   = rd_tag_i;
    wr_rank_o  = rd_rank_i;
    for (int w = 0; w < WAYS; w++) begin
      if (inuse[w]) begin
        if (hit) begin
          if (lru_i) begin
            if (WAY_W'(w) == hit_way) wr_rank_o[w] = nw_i;
            else if (rd_rank_i[w] > old_rank) wr_rank_o[w] = rd_rank_i[w] - RANK_W'(1);
          end
        end else begin
          if (WAY_W'(w) == vic_way) begin
            wr_valid_o[w] = 1'b1;
            wr_tag_o[w]   = tag_i;
            wr_rank_o[w]  = nw_i;
          end else if (rd_rank_i[w] != '0) begin
            wr_rank_o[w] = rd_rank_i[w] - RANK_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/set_assoc_cache_tag_fifo_lru.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_fifo_lru
// Set-associative tag store with FIFO or LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
// Flow: a new address is taken only after the last lookup has written back
//   its row (set memory read, then compare and write-back of the same row).
// Result: enters the output register after the registered set memory read,
//   once that register is free; a held result stalls the lookup until taken.
// Reset: config regs and totals to defaults; then a clearing pass zeroes
//   every set row in turn, during which no address is taken.
// Config writes are accepted at any time, including during the clear.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_fifo_lru #(
  parameter int unsigned SETS      = 64,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // address channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sac_pkg::ADDR_W-1:0]     address_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                hit_o,
  output logic      [sac_pkg::KIND_W-1:0]     miss_kind_o,
  output logic      [sac_pkg::WAY_OUT_W-1:0]  way_used_o,
  output logic      [sac_pkg::SET_OUT_W-1:0]  set_used_o,
  output logic      [sac_pkg::CNT_W-1:0]      hit_total_o,
  output logic      [sac_pkg::CNT_W-1:0]      miss_total_o
);

  import sac_pkg::*;

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RANK_W = $clog2(WAYS + 1);
  localparam int unsigned TAG_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned ROW_W  = WAYS * (1 + TAG_W + RANK_W);
  // largest b with 2^b <= SETS, capped
  localparam int unsigned LOG_SETS = $clog2(SETS + 1) - 1;
  localparam int unsigned MAX_IB   = (LOG_SETS < IB_CAP) ? LOG_SETS : IB_CAP;
  localparam logic [ADDR_W-1:0] AMASK =
    (ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  // control states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [SET_W-1:0] clr_q, clr_d;

  // configuration registers
  logic              policy_q;
  logic [OFF_W-1:0]  off_q;
  logic [IB_W-1:0]   ib_q;
  logic [NWAY_W-1:0] nway_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIFO;
      off_q    <= OFF_W'(4);
      ib_q     <= IB_W'(6);
      nway_q   <= NWAY_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLICY: policy_q <= cfg_data_i[0];
        CFG_OFFSET: off_q    <= cfg_data_i[OFF_W-1:0];
        CFG_INDEX:  ib_q     <= cfg_data_i[IB_W-1:0];
        CFG_WAYS:   nway_q   <= cfg_data_i[NWAY_W-1:0];
        default: ;
      endcase
    end
  end

  // effective associativity, clamped to 1..WAYS
  logic [RANK_W-1:0] nw;
  always_comb begin
    if (nway_q == '0)               nw = RANK_W'(1);
    else if (32'(nway_q) > WAYS)    nw = RANK_W'(WAYS);
    else                            nw = RANK_W'(nway_q);
  end

  // address split at transfer time
  logic [ADDR_W-1:0] addr_m, set_full, tag_full;
  logic [3:0]        ib_eff;
  logic [4:0]        tag_sh;

  always_comb begin
    addr_m   = address_i & AMASK;
    ib_eff   = (32'(ib_q) > MAX_IB) ? 4'(MAX_IB) : {1'b0, ib_q};
    set_full = (addr_m >> off_q) & ((ADDR_W'(1) << ib_eff) - ADDR_W'(1));
    tag_sh   = 5'(off_q) + 5'(ib_eff);
    tag_full = addr_m >> tag_sh;
  end

  logic in_xfer, adv;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // finish the lookup once the output register is free or being drained
  assign adv        = (state_q == ST_LOOK) && (!out_valid_o || out_ready_i);

  // lookup payload
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_OUT_W-1:0] set_out_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      set_q     <= set_full[SET_W-1:0];
      set_out_q <= set_full[SET_OUT_W-1:0];
      tag_q     <= tag_full[TAG_W-1:0];
    end
  end

  // state machine: clear sweep, idle, lookup
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (adv) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // set memory: one row per set = {valid, tags, ranks}
  logic [ROW_W-1:0] rd_row, wr_row, ram_wdata;
  logic [SET_W-1:0] ram_waddr;
  logic             ram_we;

  logic [WAYS-1:0]             rd_valid, wr_valid;
  logic [WAYS-1:0][TAG_W-1:0]  rd_tag, wr_tag;
  logic [WAYS-1:0][RANK_W-1:0] rd_rank, wr_rank;

  assign {rd_valid, rd_tag, rd_rank} = rd_row;
  assign wr_row    = {wr_valid, wr_tag, wr_rank};
  assign ram_we    = (state_q == ST_CLEAR) || adv;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wr_row;

  sac_ram #(
    .DEPTH (SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (set_full[SET_W-1:0]),
    .rdata_o (rd_row)
  );

  lookup_t lk;

  sac_way_sel #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W)
  ) u_way_sel (
    .rd_valid_i (rd_valid),
    .rd_tag_i   (rd_tag),
    .rd_rank_i  (rd_rank),
    .tag_i      (tag_q),
    .nw_i       (nw),
    .lru_i      (policy_q == POLICY_LRU),
    .res_o      (lk),
    .wr_valid_o (wr_valid),
    .wr_tag_o   (wr_tag),
    .wr_rank_o  (wr_rank)
  );

  // saturating totals; they only move when a result enters the output
  // register, so they always match the result on display
  logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (adv) begin
      if (lk.hit) begin
        if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
      end else begin
        if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + CNT_W'(1);
      end
    end
  end

  // output register
  logic out_valid_q;
  logic hit_q;
  logic [KIND_W-1:0]    kind_q;
  logic [WAY_OUT_W-1:0] way_q;
  logic [SET_OUT_W-1:0] set_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q      <= lk.hit;
      kind_q     <= lk.kind;
      way_q      <= WAY_OUT_W'(lk.way);
      set_used_q <= set_out_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign miss_kind_o  = kind_q;
  assign way_used_o   = way_q;
  assign set_used_o   = set_used_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

  // ---------------------------------------------------------------- checks
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("address taken during clear sweep");

  a_xfer_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_LOOK))
    else $error("lookup not started after transfer");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && lk.hit) |=>
      ((hit_cnt_q == $past(hit_cnt_q) + CNT_W'(1)) || ($past(hit_cnt_q) == '1)))
    else $error("hit total not advanced");

  a_miss_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(miss_cnt_q))
    else $error("miss total moved without a lookup");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("finished lookup did not reach output");

endmodule

`default_nettype wire

// ===== bench/tb_set_assoc_cache_tag_fifo_lru.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_fifo_lru
// Self-checking bench for the set-associative tag store. A behavioral copy of
// the tag array predicts hit/miss, victim way, set and running totals for
// every accepted address. Each result transfer is checked against that
// prediction in order. Register settings change between phases, and both
// channels see random backpressure in the directed part and the first four phases.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_fifo_lru;
  import sac_pkg::*;

  localparam int unsigned NSETS          = 64;
  localparam int unsigned NWAYS          = 4;
  localparam int unsigned MAX_IB         = 6;     // largest b with 2^b <= NSETS
  localparam int unsigned SEG_ITEMS      = 288;   // random addresses per phase
  localparam int unsigned NUM_SEGS       = 6;
  localparam int unsigned HOLD_CYCLES    = 400;   // long result-side stall
  localparam int unsigned DRAIN_CYCLES   = 8;     // margin after the last result
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // one result transfer, field by field
  typedef struct {
    logic                 hit;
    logic [KIND_W-1:0]    kind;
    logic [WAY_OUT_W-1:0] way;
    logic [SET_OUT_W-1:0] set_idx;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
  } lookup_result_t;

  // --------------------------------------------------------------------------
  // Tag store predictor plus the queue of predicted lookups
  // --------------------------------------------------------------------------
  class tag_store_checker;
    bit                valid_q [NSETS*NWAYS];
    logic [ADDR_W-1:0] tag_q   [NSETS*NWAYS];
    logic [2:0]        rank_q  [NSETS*NWAYS];   // 0 never filled, 1 oldest
    logic [CNT_W-1:0]  hits_q;
    logic [CNT_W-1:0]  misses_q;

    logic              policy_q;
    logic [OFF_W-1:0]  offset_bits_q;
    logic [IB_W-1:0]   index_bits_q;
    logic [NWAY_W-1:0] ways_q;

    lookup_result_t    expected_lookups[$];
    int unsigned       n_checked;
    int unsigned       n_err;
    int unsigned       n_hit;
    int unsigned       n_compulsory;
    int unsigned       n_conflict;

    function new();
      foreach (valid_q[i]) begin
        valid_q[i] = 1'b0;
        tag_q[i]   = '0;
        rank_q[i]  = '0;
      end
      hits_q        = '0;
      misses_q      = '0;
      policy_q      = POLICY_FIFO;
      offset_bits_q = 4'd4;
      index_bits_q  = 3'd6;
      ways_q        = 3'd4;
      n_checked     = 0;
      n_err         = 0;
      n_hit         = 0;
      n_compulsory  = 0;
      n_conflict    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_POLICY: policy_q      = data[0];
        CFG_OFFSET: offset_bits_q = data[3:0];
        CFG_INDEX:  index_bits_q  = data[2:0];
        CFG_WAYS:   ways_q        = data[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_index_bits();
      return (index_bits_q > MAX_IB) ? MAX_IB : index_bits_q;
    endfunction

    function int unsigned pending();
      return expected_lookups.size();
    endfunction

    // Predict one access and update the shadow tag store.
    function void note_address(logic [ADDR_W-1:0] addr);
      int unsigned       ib, nw, sidx, base, way, w;
      bit                is_hit, found;
      logic [ADDR_W-1:0] tag;
      logic [2:0]        old_rank;
      logic [KIND_W-1:0] kind;
      lookup_result_t    r;
      ib = eff_index_bits();
      nw = ways_q;
      if (nw < 1) nw = 1;
      if (nw > NWAYS) nw = NWAYS;
      sidx = (addr >> offset_bits_q) & ((1 << ib) - 1);
      tag  = addr >> (offset_bits_q + ib);
      base = sidx * NWAYS;
      is_hit = 1'b0;
      way    = 0;
      for (w = 0; w < nw; w++)
        if (!is_hit && valid_q[base+w] && tag_q[base+w] == tag) begin
          is_hit = 1'b1;
          way    = w;
        end

      if (is_hit) begin
        kind = KIND_HIT;
        if (hits_q != '1) hits_q++;
        // LRU: promote the hit line, close the gap it leaves
        if (policy_q == POLICY_LRU) begin
          old_rank = rank_q[base+way];
          for (w = 0; w < nw; w++)
            if (w != way && rank_q[base+w] > old_rank) rank_q[base+w]--;
          rank_q[base+way] = 3'(nw);
        end
      end else begin
        found = 1'b0;
        for (w = 0; w < nw; w++)
          if (!found && !valid_q[base+w]) begin
            way   = w;
            found = 1'b1;
          end
        if (found) begin
          kind = KIND_COMPULSORY;
        end else begin
          kind = KIND_CONFLICT;
          for (w = 0; w < nw; w++)
            if (!found && rank_q[base+w] == 3'd1) begin
              way   = w;
              found = 1'b1;
            end
          // no oldest line (ways shrank): first way of lowest rank
          if (!found) begin
            way = 0;
            for (w = 1; w < nw; w++)
              if (rank_q[base+w] < rank_q[base+way]) way = w;
          end
        end
        if (misses_q != '1) misses_q++;
        for (w = 0; w < nw; w++)
          if (w != way && rank_q[base+w] >= 3'd1) rank_q[base+w]--;
        valid_q[base+way] = 1'b1;
        tag_q[base+way]   = tag;
        rank_q[base+way]  = 3'(nw);
      end

      r.hit     = is_hit;
      r.kind    = kind;
      r.way     = way[WAY_OUT_W-1:0];
      r.set_idx = sidx[SET_OUT_W-1:0];
      r.hits    = hits_q;
      r.misses  = misses_q;
      expected_lookups.push_back(r);
    endfunction

    function void check_lookup(lookup_result_t got);
      lookup_result_t e;
      if (expected_lookups.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("%0t: result transfer with nothing predicted (hit=%0b way=%0d set=%0d)",
                   $realtime, got.hit, got.way, got.set_idx);
        return;
      end
      e = expected_lookups.pop_front();
      n_checked++;
      case (e.kind)
        KIND_HIT:        n_hit++;
        KIND_COMPULSORY: n_compulsory++;
        default:         n_conflict++;
      endcase
      if (got.hit !== e.hit || got.kind !== e.kind || got.way !== e.way ||
          got.set_idx !== e.set_idx || got.hits !== e.hits || got.misses !== e.misses) begin
        n_err++;
        if (n_err <= 10) begin
          $display("%0t: mismatch on result %0d", $realtime, n_checked);
          $display("  exp hit=%0b kind=%0d way=%0d set=%0d hits=%0d misses=%0d",
                   e.hit, e.kind, e.way, e.set_idx, e.hits, e.misses);
          $display("  got hit=%0b kind=%0d way=%0d set=%0d hits=%0d misses=%0d",
                   got.hit, got.kind, got.way, got.set_idx, got.hits, got.misses);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [ADDR_W-1:0]     address_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [KIND_W-1:0]     miss_kind_o;
  logic [WAY_OUT_W-1:0]  way_used_o;
  logic [SET_OUT_W-1:0]  set_used_o;
  logic [CNT_W-1:0]      hit_total_o;
  logic [CNT_W-1:0]      miss_total_o;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  set_assoc_cache_tag_fifo_lru DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .miss_kind_o  (miss_kind_o),
    .way_used_o   (way_used_o),
    .set_used_o   (set_used_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o)
  );

  tag_store_checker tag_chk;
  lookup_result_t   seen_lookup;
  logic [ADDR_W-1:0] tag_pool [6];    // tags reused within a phase to get hits

  int unsigned send_idle_pct = 0;     // chance per cycle the sender holds off
  int unsigned recv_idle_pct = 0;     // chance per cycle ready is low
  int unsigned n_sent        = 0;
  int unsigned n_settings    = 1;     // reset values count as the first
  int unsigned idle_cycles   = 0;
  bit          hold_req      = 1'b0;  // asks the receiver for one long stall
  bit          hold_done     = 1'b0;

  // --------------------------------------------------------------------------
  // Driving tasks. Inputs change on the falling edge only; every falling edge
  // gives in_valid_i at most one assignment.
  // --------------------------------------------------------------------------
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    // wait for the transfer; valid and address stay put meanwhile
    do @(posedge clk_i); while (!in_ready_o);
    tag_chk.note_address(addr);
    n_sent++;
  endtask

  // Drop valid and let every predicted result come back before touching
  // the registers.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tag_chk.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    tag_chk.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // All four registers; the unused upper data bits get random values so the
  // block has to ignore them.
  task automatic apply_setting(input logic pol, input logic [3:0] off,
                               input logic [2:0] ib, input logic [2:0] nw);
    write_reg(CFG_POLICY, {3'($urandom), pol});
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_INDEX,  {1'($urandom), ib});
    write_reg(CFG_WAYS,   {1'($urandom), nw});
    n_settings++;
  endtask

  // Mostly well-formed accesses: a few tags, a few sets, so lines get reused
  // and evicted. The rest are raw 32-bit noise.
  function automatic logic [ADDR_W-1:0] make_address();
    int unsigned       off, ib;
    logic [ADDR_W-1:0] sidx;
    off = tag_chk.offset_bits_q;
    ib  = tag_chk.eff_index_bits();
    if ($urandom_range(0, 99) < 20) return $urandom;
    sidx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
    return (tag_pool[$urandom_range(0, 5)] << (off + ib)) |
           ((sidx & ((1 << ib) - 1)) << off) |
           ($urandom & ((1 << off) - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random ready, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        int unsigned hold_cnt;
        hold_done   = 1'b1;
        hold_cnt    = 0;
        out_ready_i <= 1'b0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
          hold_cnt++;
        end
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_lookup.hit     = hit_o;
      seen_lookup.kind    = miss_kind_o;
      seen_lookup.way     = way_used_o;
      seen_lookup.set_idx = set_used_o;
      seen_lookup.hits    = hit_total_o;
      seen_lookup.misses  = miss_total_o;
      tag_chk.check_lookup(seen_lookup);
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, tag_chk.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tag_chk = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, under the first backpressure mode
    send_idle_pct = 33;
    recv_idle_pct = 65;

    // reset setting: FIFO, 16-byte lines, 64 sets, 4 ways
    send_address(32'h0000_0000);   // compulsory, set 0
    send_address(32'hFFFF_FFFF);   // all ones, set 63
    send_address(32'h0000_000F);   // same line, hit
    send_address(32'h0000_0400);   // fill the rest of set 0
    send_address(32'h0000_0800);
    send_address(32'h0000_0C00);
    send_address(32'h0000_1000);   // set full: evict the oldest
    send_address(32'h0000_0000);   // FIFO conflict again

    settle();
    write_reg(CFG_POLICY, {3'b000, POLICY_LRU});
    send_address(32'h0000_0800);   // LRU hit moves the line to newest
    send_address(32'h0000_1400);
    send_address(32'h0000_0800);
    send_address(32'h0000_1000);   // way 0 becomes newest

    // one way in use while way 0 holds the newest rank: no oldest line exists
    settle();
    write_reg(CFG_WAYS, 4'd0);     // zero ways behaves as one
    send_address(32'h0000_2000);
    send_address(32'h0000_2000);

    // offset past the normal range, too many index bits, too many ways
    settle();
    write_reg(CFG_OFFSET, 4'd15);
    write_reg(CFG_INDEX,  4'd7);
    write_reg(CFG_WAYS,   4'd7);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_8000);
    send_address(32'h0000_7FFF);

    // byte lines, single set: whole address is the tag
    settle();
    write_reg(CFG_OFFSET, 4'd0);
    write_reg(CFG_INDEX,  4'd0);
    send_address(32'h0000_0000);
    send_address(32'h0000_0001);
    send_address(32'hFFFF_FFFF);

    // random phases; each gets its own setting and tag pool
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      settle();
      case (seg)
        0: apply_setting(POLICY_FIFO, 4'd4,  3'd6, 3'd4);
        1: apply_setting(POLICY_LRU,  4'd0,  3'd2, 3'd2);
        2: apply_setting(POLICY_FIFO, 4'd8,  3'd0, 3'd1);
        3: apply_setting(POLICY_LRU,  4'd15, 3'd7, 3'd5);
        4: apply_setting(POLICY_LRU,  4'd6,  3'd3, 3'd3);
        default: apply_setting(POLICY_FIFO, 4'd2, 3'd1, 3'd0);
      endcase
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      // sender idles 33/100 and receiver 65/100, then swapped, then none
      if (seg < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 65;
      end else if (seg < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // last phase: receiver stalls long so the block backs up its input
      if (seg == NUM_SEGS - 1) hold_req = 1'b1;
      repeat (SEG_ITEMS) send_address(make_address());
    end

    settle();

    $display("covered %0d addresses over %0d register settings, FIFO and LRU, with backpressure",
             n_sent, n_settings);
    $display("checked %0d results: %0d hits, %0d compulsory, %0d conflict, %0d mismatches",
             tag_chk.n_checked, tag_chk.n_hit, tag_chk.n_compulsory, tag_chk.n_conflict,
             tag_chk.n_err);
    if (tag_chk.n_err == 0 && tag_chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (tag_chk.pending() != 0)
        $display("%0d predicted results never arrived", tag_chk.pending());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== set_assoc_cache_tag_fifo_lru.f =====
design/sac_pkg.sv
design/sac_ram.sv
design/sac_way_sel.sv
design/set_assoc_cache_tag_fifo_lru.sv
bench/tb_set_assoc_cache_tag_fifo_lru.sv
